// ===== hw/rtl/rrwl_pkg.sv =====
// Shared types and constants for the row reader/writer lock table.
// Request and status codes, the decoded request class and parameter defaults.
// No dependencies.
package rrwl_pkg;

	localparam int unsigned ROWS_DEF       = 1024;
	localparam int unsigned OWNER_BITS_DEF = 16;
	localparam int unsigned ROW_IN_W       = 10;
	localparam int unsigned TXN_W          = 16;
	localparam int unsigned HOLDER_W       = 16;
	localparam int unsigned TIME_W         = 32;
	localparam logic [TIME_W-1:0] WAIT_LIMIT_RST = 32'd1000000;

	localparam logic [2:0] REQ_RLOCK   = 3'd0;
	localparam logic [2:0] REQ_WLOCK   = 3'd1;
	localparam logic [2:0] REQ_RUNLOCK = 3'd2;
	localparam logic [2:0] REQ_WUNLOCK = 3'd3;
	localparam logic [2:0] REQ_NONE    = 3'd4;

	typedef enum logic [2:0] {
		OP_RLOCK,
		OP_WLOCK,
		OP_RUNLOCK,
		OP_WUNLOCK,
		OP_NONE,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RETRY,
		ST_TIMEOUT,
		ST_UNEXP
	} status_t;

	typedef struct packed {
		op_t  op;
		logic holds;
		logic timed_out;
	} cls_t;

endpackage

// ===== hw/rtl/rrwl_front.sv =====
// Front end: accepts requests, decodes them, folds the row index into the table
// and compares the elapsed time against the wait limit. Uses rrwl_pkg.
module rrwl_front #(
	parameter int unsigned ROWS       = rrwl_pkg::ROWS_DEF,
	parameter int unsigned OWNER_BITS = rrwl_pkg::OWNER_BITS_DEF,
	parameter int unsigned AW         = $clog2(ROWS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rrwl_pkg::TIME_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        req_type,
	input  logic [rrwl_pkg::ROW_IN_W-1:0]     row_index,
	input  logic [rrwl_pkg::TXN_W-1:0]        txn_id,
	input  logic                              holds_read,
	input  logic [rrwl_pkg::TIME_W-1:0]       elapsed_time,
	input  logic                              clear_busy,
	input  logic                              q_full,
	output logic                              q_push,
	output rrwl_pkg::cls_t                    q_cls,
	output logic [AW-1:0]                     q_addr,
	output logic [OWNER_BITS-1:0]             q_txn
);
	import rrwl_pkg::*;

	localparam int unsigned MW = (AW > ROW_IN_W) ? AW : ROW_IN_W;
	localparam int unsigned TW = (OWNER_BITS > TXN_W) ? OWNER_BITS : TXN_W;

	logic [TIME_W-1:0] wait_limit_q;
	logic [MW-1:0]     row_ext;
	logic [TW-1:0]     txn_ext;
	op_t               op;

	// Remainder by the row count through shifted compare-and-subtract steps.
	function automatic logic [ROW_IN_W-1:0] row_mod(input logic [ROW_IN_W-1:0] v);
		logic [ROW_IN_W-1:0] r;
		longint unsigned     step;
		r = v;
		for (int k = ROW_IN_W - 1; k >= 0; k--) begin
			step = longint'(ROWS) << k;
			if (step < (64'd1 << ROW_IN_W)) begin
				if (64'(r) >= step) begin
					r = r - ROW_IN_W'(step);
				end
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q <= WAIT_LIMIT_RST;
		end else if (cfg_we) begin
			wait_limit_q <= cfg_wdata;
		end
	end

	always_comb begin
		unique case (req_type)
			REQ_RLOCK:   op = OP_RLOCK;
			REQ_WLOCK:   op = OP_WLOCK;
			REQ_RUNLOCK: op = OP_RUNLOCK;
			REQ_WUNLOCK: op = OP_WUNLOCK;
			REQ_NONE:    op = OP_NONE;
			default:     op = OP_BAD;
		endcase
	end

	assign row_ext = MW'(row_mod(row_index));
	assign txn_ext = TW'(txn_id);

	assign in_ready        = !q_full && !clear_busy;
	assign q_push          = in_valid && in_ready;
	assign q_cls.op        = op;
	assign q_cls.holds     = holds_read;
	assign q_cls.timed_out = elapsed_time > wait_limit_q;
	assign q_addr          = row_ext[AW-1:0];
	assign q_txn           = txn_ext[OWNER_BITS-1:0];

endmodule

// ===== hw/rtl/rrwl_fifo.sv =====
// Two-entry queue between the front end and the table engine.
// Generic payload width; no package dependency.
module rrwl_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/rrwl_back.sv =====
// Table engine: holds the lock words in a memory, runs one request per beat
// with forwarding for back-to-back requests to the same row. Uses rrwl_pkg.
module rrwl_back #(
	parameter int unsigned ROWS       = rrwl_pkg::ROWS_DEF,
	parameter int unsigned OWNER_BITS = rrwl_pkg::OWNER_BITS_DEF,
	parameter int unsigned AW         = $clog2(ROWS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	output logic                            clear_busy,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  rrwl_pkg::cls_t                  q_cls,
	input  logic [AW-1:0]                   q_addr,
	input  logic [OWNER_BITS-1:0]           q_txn,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rrwl_pkg::status_t               status,
	output logic                            is_exclusive,
	output logic [rrwl_pkg::HOLDER_W-1:0]   holder_field
);
	import rrwl_pkg::*;

	localparam int unsigned WW = OWNER_BITS + 1;
	localparam int unsigned TW = (OWNER_BITS > HOLDER_W) ? OWNER_BITS : HOLDER_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic                  excl_q;
	logic [HOLDER_W-1:0]   holder_q;
	cls_t                  cur_cls_q;
	logic [AW-1:0]         cur_addr_q;
	logic [OWNER_BITS-1:0] cur_txn_q;
	logic                  fwd_q;
	logic [WW-1:0]         fwd_word_q;

	logic [WW-1:0]         mem [ROWS];
	logic [WW-1:0]         rd_q;

	logic                  done;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [WW-1:0]         mem_wd;
	logic [WW-1:0]         word;
	logic [WW-1:0]         new_word;
	logic                  refused;
	status_t               new_status;
	logic                  excl;
	logic [OWNER_BITS-1:0] low;
	logic                  owned;
	logic [TW-1:0]         holder_ext;

	assign done  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign q_pop = !q_empty && ((state_q == S_IDLE) || done);

	// The word seen by the current request: the one just written if it hit
	// the same row, otherwise what the memory read returned.
	assign word  = fwd_q ? fwd_word_q : rd_q;
	assign excl  = word[OWNER_BITS];
	assign low   = word[OWNER_BITS-1:0];
	assign owned = excl && (low == cur_txn_q);

	always_comb begin
		new_word   = word;
		refused    = 1'b0;
		new_status = ST_OK;
		unique case (cur_cls_q.op)
			OP_RLOCK: begin
				if (owned || cur_cls_q.holds) begin
					new_word = word;
				end else if (!excl && (low != {OWNER_BITS{1'b1}})) begin
					new_word = word + WW'(1);
				end else begin
					refused = 1'b1;
				end
			end
			OP_WLOCK: begin
				if (owned) begin
					new_word = word;
				end else if (word == WW'(cur_cls_q.holds)) begin
					new_word = {1'b1, cur_txn_q};
				end else begin
					refused = 1'b1;
				end
			end
			OP_RUNLOCK: begin
				if (!excl && (word != '0)) begin
					new_word = word - WW'(1);
				end
			end
			OP_WUNLOCK: begin
				if (owned) begin
					new_word = '0;
				end else begin
					new_status = ST_UNEXP;
				end
			end
			OP_NONE: begin
				new_word = word;
			end
			default: begin
				refused = 1'b1;
			end
		endcase
		if (refused) begin
			new_status = cur_cls_q.timed_out ? ST_TIMEOUT : ST_RETRY;
		end
	end

	assign holder_ext = TW'(new_word[OWNER_BITS-1:0]);

	assign mem_we = (state_q == S_CLEAR) || done;
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : cur_addr_q;
	assign mem_wd = (state_q == S_CLEAR) ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (q_pop) begin
			rd_q <= mem[q_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						out_valid_q <= 1'b1;
						status_q    <= new_status;
						excl_q      <= new_word[OWNER_BITS];
						holder_q    <= holder_ext[HOLDER_W-1:0];
						fwd_word_q  <= new_word;
						if (!q_pop) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (q_pop) begin
				cur_cls_q  <= q_cls;
				cur_addr_q <= q_addr;
				cur_txn_q  <= q_txn;
				fwd_q      <= done && (q_addr == cur_addr_q);
			end
		end
	end

	assign clear_busy   = state_q == S_CLEAR;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign is_exclusive = excl_q;
	assign holder_field = holder_q;

endmodule

// ===== hw/rtl/row_reader_writer_lock_table_top.sv =====
// Row reader/writer lock table, top level. Uses rrwl_pkg.
// A request goes via the queue and engine registers to a registered result.
// Throughput: one request per cycle while out_ready is high; the lock-word memory
// has one read and one write port, and a request to the row just written takes
// the new word. Reset: wait_limit returns to 1000000 and the table is swept to
// zero, one row per cycle up to row ROWS-1, while in_ready is held low.
module row_reader_writer_lock_table_top #(
	parameter int unsigned ROWS       = rrwl_pkg::ROWS_DEF,
	parameter int unsigned OWNER_BITS = rrwl_pkg::OWNER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rrwl_pkg::TIME_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic [rrwl_pkg::ROW_IN_W-1:0]   row_index,
	input  logic [rrwl_pkg::TXN_W-1:0]      txn_id,
	input  logic                            holds_read,
	input  logic [rrwl_pkg::TIME_W-1:0]     elapsed_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic                            is_exclusive,
	output logic [rrwl_pkg::HOLDER_W-1:0]   holder_field
);
	import rrwl_pkg::*;

	localparam int unsigned AW = $clog2(ROWS);
	localparam int unsigned QW = $bits(cls_t) + AW + OWNER_BITS;

	logic                  clear_busy;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	cls_t                  push_cls;
	logic [AW-1:0]         push_addr;
	logic [OWNER_BITS-1:0] push_txn;
	cls_t                  pop_cls;
	logic [AW-1:0]         pop_addr;
	logic [OWNER_BITS-1:0] pop_txn;
	logic [QW-1:0]         pop_data;
	status_t               status_e;

	rrwl_front #(
		.ROWS       (ROWS),
		.OWNER_BITS (OWNER_BITS),
		.AW         (AW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.row_index    (row_index),
		.txn_id       (txn_id),
		.holds_read   (holds_read),
		.elapsed_time (elapsed_time),
		.clear_busy   (clear_busy),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cls        (push_cls),
		.q_addr       (push_addr),
		.q_txn        (push_txn)
	);

	rrwl_fifo #(
		.W (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_cls, push_addr, push_txn}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	assign {pop_cls, pop_addr, pop_txn} = pop_data;

	rrwl_back #(
		.ROWS       (ROWS),
		.OWNER_BITS (OWNER_BITS),
		.AW         (AW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear_busy   (clear_busy),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_cls        (pop_cls),
		.q_addr       (pop_addr),
		.q_txn        (pop_txn),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status_e),
		.is_exclusive (is_exclusive),
		.holder_field (holder_field)
	);

	assign status = 2'(status_e);

endmodule

// ===== verif/lock_table_checker.sv =====
// Checker for the row reader/writer lock table: mirrors the lock words and the wait limit,
// predicts the outcome of every accepted request beat and compares it with the result beats.
// Depends on rrwl_pkg for codes and widths.
module lock_table_checker #(
	parameter int unsigned ROWS       = rrwl_pkg::ROWS_DEF,
	parameter int unsigned OWNER_BITS = rrwl_pkg::OWNER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrwl_pkg::TIME_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [2:0]                    req_type,
	input  logic [rrwl_pkg::ROW_IN_W-1:0] row_index,
	input  logic [rrwl_pkg::TXN_W-1:0]    txn_id,
	input  logic                          holds_read,
	input  logic [rrwl_pkg::TIME_W-1:0]   elapsed_time,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    status,
	input  logic                          is_exclusive,
	input  logic [rrwl_pkg::HOLDER_W-1:0] holder_field,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrwl_pkg::*;

	localparam int HW = HOLDER_W;

	typedef logic [OWNER_BITS:0]   word_t;
	typedef logic [OWNER_BITS-1:0] owner_t;
	typedef logic [HW-1:0]         holder_t;

	typedef struct packed {
		status_t status;
		logic    excl;
		holder_t holder;
	} lock_outcome_t;

	word_t           lock_word [ROWS];
	logic [TIME_W-1:0] wait_limit;
	lock_outcome_t   outcomes_due [$];
	lock_outcome_t   due;

	task automatic report_mismatch(input string msg);
		$display("%0t ns lock table check: %s", $time, msg);
		fail_count++;
	endtask

	// Makes one attempt on the addressed row, updates the mirror and returns the outcome.
	function automatic lock_outcome_t apply_request(input logic [2:0] req,
			input logic [ROW_IN_W-1:0] row_in, input logic [TXN_W-1:0] txn,
			input logic holds, input logic [TIME_W-1:0] elapsed);
		int unsigned   row;
		word_t         word;
		owner_t        me;
		logic          owns;
		logic          refused;
		lock_outcome_t res;
		row = row_in % ROWS;
		word = lock_word[row];
		me = owner_t'(txn);
		owns = word[OWNER_BITS] && (word[OWNER_BITS-1:0] == me);
		refused = 1'b0;
		res.status = ST_OK;
		case (req)
			REQ_RLOCK: begin
				if (owns || holds) begin
				end else if (!word[OWNER_BITS] && word[OWNER_BITS-1:0] != '1) begin
					word = word + 1'b1;
				end else begin
					refused = 1'b1;
				end
			end
			REQ_WLOCK: begin
				// A sole reader upgrades; a free row is taken outright when no read is held.
				if (owns) begin
				end else if (word == word_t'(holds)) begin
					word = {1'b1, me};
				end else begin
					refused = 1'b1;
				end
			end
			REQ_RUNLOCK: begin
				if (!word[OWNER_BITS] && word != '0)
					word = word - 1'b1;
			end
			REQ_WUNLOCK: begin
				if (owns)
					word = '0;
				else
					res.status = ST_UNEXP;
			end
			REQ_NONE: begin
			end
			default: refused = 1'b1;
		endcase
		if (refused)
			res.status = (elapsed > wait_limit) ? ST_TIMEOUT : ST_RETRY;
		lock_word[row] = word;
		res.excl = word[OWNER_BITS];
		res.holder = holder_t'(word[OWNER_BITS-1:0]);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (lock_word[i])
				lock_word[i] = '0;
			wait_limit = WAIT_LIMIT_RST;
			outcomes_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Results pass through the queue and engine registers first, so a result beat never
			// belongs to a request beat taken at the same edge.
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch("result beat with no request outstanding");
				end else begin
					due = outcomes_due.pop_front();
					if (status !== due.status)
						report_mismatch($sformatf("status got %0d want %0d", status,
							due.status));
					if (is_exclusive !== due.excl)
						report_mismatch($sformatf("is_exclusive got %0b want %0b",
							is_exclusive, due.excl));
					if (holder_field !== due.holder)
						report_mismatch($sformatf("holder_field got %h want %h",
							holder_field, due.holder));
				end
			end
			if (in_valid && in_ready)
				outcomes_due.push_back(apply_request(req_type, row_index, txn_id,
					holds_read, elapsed_time));
			if (cfg_we)
				wait_limit = cfg_wdata;
			pending = outcomes_due.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the row reader/writer lock table: clock, reset, request stimulus,
// result back-pressure and the final verdict. Depends on rrwl_pkg, lock_table_checker
// and row_reader_writer_lock_table_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrwl_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [2:0] REQ_RSVD5 = 3'd5;
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0]          req;
		logic [ROW_IN_W-1:0] row;
		logic [TXN_W-1:0]    txn;
		logic                holds;
		logic [TIME_W-1:0]   elapsed;
	} lock_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [TIME_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [2:0] req_type;
	logic [ROW_IN_W-1:0] row_index;
	logic [TXN_W-1:0] txn_id;
	logic holds_read;
	logic [TIME_W-1:0] elapsed_time;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic is_exclusive;
	logic [HOLDER_W-1:0] holder_field;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	logic long_hold;
	logic [TIME_W-1:0] wait_limit_now;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	row_reader_writer_lock_table_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.row_index    (row_index),
		.txn_id       (txn_id),
		.holds_read   (holds_read),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.is_exclusive (is_exclusive),
		.holder_field (holder_field)
	);

	lock_table_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.row_index    (row_index),
		.txn_id       (txn_id),
		.holds_read   (holds_read),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.is_exclusive (is_exclusive),
		.holder_field (holder_field),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("row_reader_writer_lock_table_top: mismatch");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off that fills the block.
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				for (n = 0; n < HOLD_CYCLES; n++) begin
					out_ready <= 1'b0;
					@(posedge clk);
				end
				long_hold <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic lock_req_t mk_req(input logic [2:0] req, input logic [ROW_IN_W-1:0] row,
			input logic [TXN_W-1:0] txn, input logic holds, input logic [TIME_W-1:0] elapsed);
		lock_req_t r;
		r.req = req;
		r.row = row;
		r.txn = txn;
		r.holds = holds;
		r.elapsed = elapsed;
		return r;
	endfunction

	// Valid drops here only when a gap is taken, so back-to-back beats keep it high.
	task automatic send_req(input lock_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		row_index <= r.row;
		txn_id <= r.txn;
		holds_read <= r.holds;
		elapsed_time <= r.elapsed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_wait_limit(input logic [TIME_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		wait_limit_now = v;
	endtask

	// Elapsed times cluster around the limit so both sides of the compare show up.
	function automatic logic [TIME_W-1:0] pick_elapsed();
		case ($urandom_range(3))
			0: return wait_limit_now;
			1: return wait_limit_now + 1'b1;
			2: return $urandom;
			default: return $urandom_range(15);
		endcase
	endfunction

	function automatic logic [TXN_W-1:0] pick_txn();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001;
			3: return 16'h8000;
			4: return 16'h5A5A;
			5: return 16'hA5A5;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_IN_W-1:0] pick_hot_row();
		case ($urandom_range(3))
			0: return 10'd0;
			1: return 10'd1;
			2: return 10'd512;
			default: return 10'd1023;
		endcase
	endfunction

	task automatic run_directed();
		send_req(mk_req(REQ_NONE, 10'd0, 16'h0000, 1'b0, 32'd0));
		// Read unlock and write unlock of a free row.
		send_req(mk_req(REQ_RUNLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_WUNLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		// The sole reader upgrades to exclusive.
		send_req(mk_req(REQ_WLOCK, 10'd0, 16'h0000, 1'b1, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_WLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd0, 16'hFFFF, 1'b0, WAIT_LIMIT_RST));
		send_req(mk_req(REQ_WLOCK, 10'd0, 16'hFFFF, 1'b0, WAIT_LIMIT_RST + 1'b1));
		send_req(mk_req(REQ_RUNLOCK, 10'd0, 16'hFFFF, 1'b0, 32'd0));
		send_req(mk_req(REQ_WUNLOCK, 10'd0, 16'hFFFF, 1'b0, 32'd0));
		send_req(mk_req(REQ_WUNLOCK, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_WLOCK, 10'd1023, 16'hFFFF, 1'b0, 32'd0));
		send_req(mk_req(REQ_WUNLOCK, 10'd1023, 16'hFFFF, 1'b0, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd1023, 16'h0005, 1'b0, 32'd0));
		send_req(mk_req(REQ_RLOCK, 10'd1023, 16'h0006, 1'b0, 32'd0));
		// Two readers block an upgrade and a fresh writer.
		send_req(mk_req(REQ_WLOCK, 10'd1023, 16'h0005, 1'b1, 32'hFFFF_FFFF));
		send_req(mk_req(REQ_WLOCK, 10'd1023, 16'h0007, 1'b0, 32'd0));
		send_req(mk_req(REQ_RUNLOCK, 10'd1023, 16'h0005, 1'b0, 32'd0));
		send_req(mk_req(REQ_RUNLOCK, 10'd1023, 16'h0006, 1'b0, 32'd0));
		// An upgrade claimed on a free row is refused.
		send_req(mk_req(REQ_WLOCK, 10'd1023, 16'h0007, 1'b1, 32'd0));
		send_req(mk_req(REQ_RSVD5, 10'd0, 16'h0000, 1'b0, 32'd0));
		send_req(mk_req(REQ_RSVD6, 10'd512, 16'h1234, 1'b1, 32'hFFFF_FFFF));
		send_req(mk_req(REQ_RSVD7, 10'd1023, 16'hFFFF, 1'b0, WAIT_LIMIT_RST));
	endtask

	// Mostly lock/release pairs on a few hot rows, with releases deferred so that
	// transactions contend; a quarter of the choices are unconstrained noise.
	task automatic run_random(input int n_items);
		lock_req_t releases [$];
		lock_req_t r;
		int sent;
		int pick;
		int k;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				r.req = 3'($urandom_range(7));
				r.row = ROW_IN_W'($urandom_range(1023));
				r.txn = ($urandom_range(1)) ? pick_txn() : 16'($urandom);
				r.holds = 1'($urandom_range(1));
				r.elapsed = ($urandom_range(1)) ? pick_elapsed() : $urandom;
				send_req(r);
				sent++;
			end else if (releases.size() != 0 && (pick < 55 || releases.size() >= 8)) begin
				k = $urandom_range(releases.size() - 1);
				r = releases[k];
				releases.delete(k);
				r.elapsed = pick_elapsed();
				send_req(r);
				sent++;
			end else begin
				r.row = pick_hot_row();
				r.txn = pick_txn();
				r.holds = 1'b0;
				r.elapsed = pick_elapsed();
				case ($urandom_range(3))
					0: begin
						r.req = REQ_RLOCK;
						send_req(r);
						r.req = REQ_RUNLOCK;
						releases.push_back(r);
						sent++;
					end
					1: begin
						r.req = REQ_WLOCK;
						send_req(r);
						r.req = REQ_WUNLOCK;
						releases.push_back(r);
						sent++;
					end
					2: begin
						r.req = REQ_RLOCK;
						send_req(r);
						r.req = REQ_WLOCK;
						r.holds = 1'b1;
						r.elapsed = pick_elapsed();
						send_req(r);
						r.req = REQ_WUNLOCK;
						r.holds = 1'b0;
						releases.push_back(r);
						sent += 2;
					end
					default: begin
						r.req = REQ_RLOCK;
						r.holds = 1'($urandom_range(1));
						send_req(r);
						sent++;
					end
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		row_index = '0;
		txn_id = '0;
		holds_read = 1'b0;
		elapsed_time = '0;
		long_hold = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 84;
		wait_limit_now = WAIT_LIMIT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random(270);

		set_wait_limit('0);
		send_idle_pct = 84;
		recv_idle_pct = 33;
		run_random(270);

		set_wait_limit('1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold <= 1'b1;
		run_random(130);

		set_wait_limit($urandom);
		run_random(130);

		drain();
		if (fail_count == 0 && pending == 0)
			$display("row_reader_writer_lock_table_top: match");
		else
			$display("row_reader_writer_lock_table_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rrwl_pkg.sv
hw/rtl/rrwl_front.sv
hw/rtl/rrwl_fifo.sv
hw/rtl/rrwl_back.sv
hw/rtl/row_reader_writer_lock_table_top.sv
verif/lock_table_checker.sv
verif/tb.sv
